### hdl/vrot_pkg.sv
// Package: widths, angle constants and arctangent table for the 2D vector rotator.
`default_nettype none

package vrot_pkg;

  localparam int ANGLE_W     = 16;
  localparam int FRAC_BITS   = 30;
  localparam int GAIN_W      = 31;
  localparam int RED_W       = 14;
  localparam int ANGLE_SHIFT = 10;
  localparam int ZW          = 25;
  localparam int ATAN_N      = 24;

  localparam logic signed [GAIN_W-1:0]  GAIN_Q30     = 31'sd652032874;
  localparam logic signed [ANGLE_W:0]   FULL_TURN    = 17'sd23040;
  localparam logic signed [ANGLE_W:0]   HALF_TURN    = 17'sd11520;
  localparam logic signed [ANGLE_W:0]   QUARTER_TURN = 17'sd5760;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = ZW'(2949120);
      1:       r = ZW'(1740967);
      2:       r = ZW'(919879);
      3:       r = ZW'(466945);
      4:       r = ZW'(234379);
      5:       r = ZW'(117304);
      6:       r = ZW'(58666);
      7:       r = ZW'(29335);
      8:       r = ZW'(14668);
      9:       r = ZW'(7334);
      10:      r = ZW'(3667);
      11:      r = ZW'(1833);
      12:      r = ZW'(917);
      13:      r = ZW'(458);
      14:      r = ZW'(229);
      15:      r = ZW'(115);
      16:      r = ZW'(57);
      17:      r = ZW'(29);
      18:      r = ZW'(14);
      19:      r = ZW'(7);
      20:      r = ZW'(4);
      21:      r = ZW'(2);
      22:      r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/vector_rotation_2d.sv
// Top level: pipelined CORDIC rotation of a 2D vector with saturated outputs.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o    | x_in_i, y_in_i, angle_i
//   out     | output    | out_valid_o / out_stall_i  | x_out_o, y_out_o, overflow_o
//
// One transaction per cycle while the output is not stalled, through
// min(ROTATION_STAGES, 24) + 3 register stages: gain multiply and angle
// reduction, half-turn negation, one CORDIC micro-rotation per stage, then
// rounding and saturation.
// Reset clears the stage valid bits only.
// A stalled output freezes every stage at once; in_stall_o follows it.
`default_nettype none

module vector_rotation_2d #(
  parameter int COORD_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  signed [COORD_WIDTH-1:0]         x_in_i,
  input  wire  signed [COORD_WIDTH-1:0]         y_in_i,
  input  wire  signed [vrot_pkg::ANGLE_W-1:0]   angle_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [COORD_WIDTH-1:0]         x_out_o,
  output logic signed [COORD_WIDTH-1:0]         y_out_o,
  output logic                                  overflow_o
);

  localparam int NSTG = (ROTATION_STAGES < vrot_pkg::ATAN_N) ? ROTATION_STAGES
                                                              : vrot_pkg::ATAN_N;
  localparam int PW   = COORD_WIDTH + vrot_pkg::GAIN_W;
  localparam int DW   = COORD_WIDTH + vrot_pkg::FRAC_BITS + 3;
  localparam int RW   = DW - vrot_pkg::FRAC_BITS;
  localparam int ZW   = vrot_pkg::ZW;
  localparam int RDW  = vrot_pkg::RED_W;
  localparam logic signed [DW-1:0] RND = DW'(1) << (vrot_pkg::FRAC_BITS - 1);

  logic en;

  logic signed [vrot_pkg::ANGLE_W:0] a0;
  logic signed [vrot_pkg::ANGLE_W:0] a1;
  logic signed [RDW-1:0]             a2;
  logic                              neg;
  logic signed [PW-1:0]              px;
  logic signed [PW-1:0]              py;

  logic signed [PW-1:0]  px_q;
  logic signed [PW-1:0]  py_q;
  logic signed [RDW-1:0] pz_q;
  logic                  pneg_q;
  logic                  pvld_q;

  logic signed [DW-1:0] xe;
  logic signed [DW-1:0] ye;

  logic signed [DW-1:0] x_q [0:NSTG];
  logic signed [DW-1:0] y_q [0:NSTG];
  logic signed [ZW-1:0] z_q [0:NSTG];
  logic [NSTG:0]        vld_q;

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic [RW-1:0]        xr;
  logic [RW-1:0]        yr;
  logic                 ovx;
  logic                 ovy;
  logic [COORD_WIDTH-1:0] xo;
  logic [COORD_WIDTH-1:0] yo;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Reduce the angle to a half turn, then to a quarter turn with a negation.
  always_comb begin
    a0 = {angle_i[vrot_pkg::ANGLE_W-1], angle_i};
    if (a0 > vrot_pkg::HALF_TURN) begin
      a1 = a0 - vrot_pkg::FULL_TURN;
    end else if (a0 <= -vrot_pkg::HALF_TURN) begin
      a1 = a0 + vrot_pkg::FULL_TURN;
    end else begin
      a1 = a0;
    end
    neg = 1'b0;
    a2  = RDW'(a1);
    if (a1 > vrot_pkg::QUARTER_TURN) begin
      a2  = RDW'(a1 - vrot_pkg::HALF_TURN);
      neg = 1'b1;
    end else if (a1 < -vrot_pkg::QUARTER_TURN) begin
      a2  = RDW'(a1 + vrot_pkg::HALF_TURN);
      neg = 1'b1;
    end
  end

  assign px = $signed(x_in_i) * vrot_pkg::GAIN_Q30;
  assign py = $signed(y_in_i) * vrot_pkg::GAIN_Q30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= px;
      py_q   <= py;
      pz_q   <= a2;
      pneg_q <= neg;
    end
  end

  assign xe = {{(DW-PW){px_q[PW-1]}}, px_q};
  assign ye = {{(DW-PW){py_q[PW-1]}}, py_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= pneg_q ? -xe : xe;
      y_q[0] <= pneg_q ? -ye : ye;
      z_q[0] <= {{(ZW-RDW-vrot_pkg::ANGLE_SHIFT){pz_q[RDW-1]}}, pz_q,
                 {vrot_pkg::ANGLE_SHIFT{1'b0}}};
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - vrot_pkg::atan_deg(i);
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + vrot_pkg::atan_deg(i);
        end
      end
    end
  end

  // Round to nearest Q8.8, ties up, then clamp.
  assign xs  = x_q[NSTG] + RND;
  assign ys  = y_q[NSTG] + RND;
  assign xr  = xs[DW-1:vrot_pkg::FRAC_BITS];
  assign yr  = ys[DW-1:vrot_pkg::FRAC_BITS];
  assign ovx = !((&xr[RW-1:COORD_WIDTH-1]) || !(|xr[RW-1:COORD_WIDTH-1]));
  assign ovy = !((&yr[RW-1:COORD_WIDTH-1]) || !(|yr[RW-1:COORD_WIDTH-1]));
  assign xo  = ovx ? {xr[RW-1], {(COORD_WIDTH-1){!xr[RW-1]}}} : xr[COORD_WIDTH-1:0];
  assign yo  = ovy ? {yr[RW-1], {(COORD_WIDTH-1){!yr[RW-1]}}} : yr[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_o    <= xo;
      y_out_o    <= yo;
      overflow_o <= ovx || ovy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      pvld_q      <= in_valid_i;
      vld_q       <= {vld_q[NSTG-1:0], pvld_q};
      out_valid_o <= vld_q[NSTG];
    end
  end

endmodule

`default_nettype wire

### hdl/vrot_checker.sv
// Checker: port-level assertions for the 2D vector rotator, bound to the top level.
`default_nettype none

module vrot_sva #(
  parameter int COORD_WIDTH = 16
) (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_stall_o,
  input wire                                 out_valid_o,
  input wire                                 out_stall_i,
  input wire signed [COORD_WIDTH-1:0]        x_out_o,
  input wire signed [COORD_WIDTH-1:0]        y_out_o,
  input wire                                 overflow_o
);

  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_out_o)
      && $stable(y_out_o) && $stable(overflow_o))
    else $error("stalled output transaction changed");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_ovf_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      x_out_o == CMAX || x_out_o == CMIN || y_out_o == CMAX || y_out_o == CMIN)
    else $error("overflow flagged without a clamped component");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o || rst_ni)
    else $error("output valid during reset");

endmodule

bind vector_rotation_2d vrot_sva #(
  .COORD_WIDTH(COORD_WIDTH)
) u_vrot_sva (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .x_out_o    (x_out_o),
  .y_out_o    (y_out_o),
  .overflow_o (overflow_o)
);

`default_nettype wire

### bench/vrot_checker.sv
// Checker: predicts each rotated vector and compares it with the output channel.
`timescale 1ns / 1ps

module vrot_checker #(
  parameter int COORD_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_i,
  input  wire signed [COORD_WIDTH-1:0]        x_in_i,
  input  wire signed [COORD_WIDTH-1:0]        y_in_i,
  input  wire signed [vrot_pkg::ANGLE_W-1:0]  angle_i,
  input  wire                                 out_valid_i,
  input  wire                                 out_stall_i,
  input  wire signed [COORD_WIDTH-1:0]        x_out_i,
  input  wire signed [COORD_WIDTH-1:0]        y_out_i,
  input  wire                                 overflow_i,
  output int                                  pending_o,
  output int                                  fail_count_o
);

  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint UNIT_SCALE = 64'sd1024;
  localparam longint FULL_ROT   = 64'sd23592960;
  localparam longint HALF_ROT   = 64'sd11796480;
  localparam longint QUART_ROT  = 64'sd5898240;
  localparam int     XFRAC      = 30;
  localparam int     ATAN_LEN   = 24;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          ovf;
  } rot_vec_t;

  longint atan_tab [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  rot_vec_t rotated_q [$];
  int       result_idx;

  function automatic logic signed [COORD_WIDTH-1:0] round_clamp(input longint v,
                                                                inout bit sat);
    longint lim;
    longint r;
    lim = longint'(1) <<< (COORD_WIDTH - 1);
    r = (v + (longint'(1) <<< (XFRAC - 1))) >>> XFRAC;
    if (r > lim - 1) begin
      r = lim - 1;
      sat = 1'b1;
    end else if (r < -lim) begin
      r = -lim;
      sat = 1'b1;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  function automatic rot_vec_t rotate_vector(input logic signed [COORD_WIDTH-1:0] xi,
                                             input logic signed [COORD_WIDTH-1:0] yi,
                                             input logic signed [15:0] ang);
    longint   x, y, z, dx, dy;
    int       i;
    bit       sat;
    rot_vec_t r;
    x = longint'(xi) * GAIN_Q30;
    y = longint'(yi) * GAIN_Q30;
    z = longint'(ang) * UNIT_SCALE;
    sat = 1'b0;
    while (z > HALF_ROT) z = z - FULL_ROT;
    while (z <= -HALF_ROT) z = z + FULL_ROT;
    if (z > QUART_ROT) begin
      z = z - HALF_ROT;
      x = -x;
      y = -y;
    end else if (z < -QUART_ROT) begin
      z = z + HALF_ROT;
      x = -x;
      y = -y;
    end
    for (i = 0; i < ROTATION_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    r.x = round_clamp(x, sat);
    r.y = round_clamp(y, sat);
    r.ovf = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count_o < 200) begin
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, result_idx, what, got,
               want);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rot_vec_t want;
    if (!rst_ni) begin
      pending_o    <= 0;
      result_idx   <= 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rotated_q.size() == 0) begin
          report_mismatch("unexpected transaction, x_out", x_out_i, 0);
        end else begin
          want = rotated_q.pop_front();
          if (x_out_i !== want.x) report_mismatch("x_out", x_out_i, want.x);
          if (y_out_i !== want.y) report_mismatch("y_out", y_out_i, want.y);
          if (overflow_i !== want.ovf) report_mismatch("overflow", overflow_i, want.ovf);
        end
        result_idx <= result_idx + 1;
      end
      if (in_valid_i && !in_stall_i) begin
        rotated_q.push_back(rotate_vector(x_in_i, y_in_i, angle_i));
      end
      pending_o <= rotated_q.size();
    end
  end

endmodule

### bench/vector_rotation_2d_tb.sv
// Testbench top: drives vector stimulus with random idling and gives the verdict.
`timescale 1ns / 1ps

module vector_rotation_2d_tb;

  localparam int CW             = 16;
  localparam int STAGES         = 16;
  localparam int PHASE_ITEMS    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic signed [CW-1:0]               x_in_i;
  logic signed [CW-1:0]               y_in_i;
  logic signed [vrot_pkg::ANGLE_W-1:0] angle_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [CW-1:0]               x_out_o;
  logic signed [CW-1:0]               y_out_o;
  logic                               overflow_o;

  int pending;
  int fail_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int idle_cycles;

  vector_rotation_2d #(
    .COORD_WIDTH    (CW),
    .ROTATION_STAGES(STAGES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .angle_i    (angle_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .overflow_o (overflow_o)
  );

  vrot_checker #(
    .COORD_WIDTH    (CW),
    .ROTATION_STAGES(STAGES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .angle_i     (angle_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_out_i     (x_out_o),
    .y_out_i     (y_out_o),
    .overflow_i  (overflow_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic send_vector(input logic signed [CW-1:0] xv, input logic signed [CW-1:0] yv,
                             input logic signed [15:0] av);
    int gap;
    in_valid_i <= 1'b1;
    x_in_i     <= xv;
    y_in_i     <= yv;
    angle_i    <= av;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int ph, n, sel;
    logic signed [CW-1:0] xv, yv;
    logic signed [15:0]   av;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    x_in_i       = '0;
    y_in_i       = '0;
    angle_i      = '0;
    tx_idle_pct  = 19;
    rx_stall_pct = 85;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd256, 16'sd0, 16'sd0);
    send_vector(16'sd256, 16'sd0, 16'sd5760);
    send_vector(16'sd256, 16'sd0, -16'sd5760);
    send_vector(16'sd256, 16'sd512, 16'sd5761);
    send_vector(16'sd256, 16'sd512, -16'sd5761);
    send_vector(16'sd1000, -16'sd300, 16'sd11520);
    send_vector(16'sd1000, -16'sd300, -16'sd11520);
    send_vector(-16'sd700, 16'sd1234, 16'sd23040);
    send_vector(-16'sd700, 16'sd1234, -16'sd23040);
    send_vector(16'sd4096, 16'sd4096, 16'sd17280);
    send_vector(16'sd300, 16'sd300, 16'sh7fff);
    send_vector(16'sd300, 16'sd300, 16'sh8000);
    send_vector(16'sh7fff, 16'sh7fff, 16'sd2880);
    send_vector(16'sh8000, 16'sh8000, 16'sd2880);
    send_vector(16'sh7fff, 16'sh8000, -16'sd2880);
    send_vector(16'sh8000, 16'sh8000, 16'sd11520);
    send_vector(16'sh8000, 16'sd0, 16'sd0);
    send_vector(16'sh7fff, 16'sh7fff, 16'sd0);
    send_vector(16'sd1, 16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1, -16'sd1);
    send_vector(16'sh8000, 16'sh7fff, 16'sd5760);
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 19;
          rx_stall_pct = 85;
        end
        1: begin
          tx_idle_pct  = 85;
          rx_stall_pct = 19;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        xv = CW'($urandom);
        yv = CW'($urandom);
        if ($urandom_range(9) < 2) begin
          xv = CW'($urandom_range(511) - 256);
          yv = CW'($urandom_range(511) - 256);
        end
        sel = $urandom_range(9);
        if (sel < 6) begin
          av = 16'($urandom_range(46080) - 23040);
        end else if (sel < 8) begin
          av = 16'($urandom);
        end else begin
          av = 16'(($urandom_range(8) - 4) * 5760 + $urandom_range(2) - 1);
        end
        send_vector(xv, yv, av);
      end
      wait_drained();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
